### rtl/lprd_pkg.sv
// ----------------------------------------------------------------------------
// lprd_pkg
// Shared types and constants for the length-prefixed request deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lprd_pkg;

   localparam int unsigned HeaderBytes = 4;
   localparam int unsigned QueueDepth  = 2;

   // Parser phase, one-hot
   typedef enum logic [3:0] {
      PH_COUNT   = 4'b0001,
      PH_LENGTH  = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_DONE    = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic        string_start;
      logic [31:0] string_length;
      logic [31:0] string_number;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        payload_final;
      logic        request_done;
      logic        request_status;
   } rsp_type;

   // Compact action record passed from the parser to the output stage.
   // value carries the string length on a start, the byte in [7:0] on payload.
   typedef struct packed {
      logic        start;
      logic        payload;
      logic        final_byte;
      logic        done;
      logic        status;
      logic [31:0] value;
      logic [31:0] number;
   } op_type;

   // Queue status toward the parser
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

### rtl/length_prefixed_request_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer
// Streams a request buffer byte by byte: reads a string count, then a length
// header and payload for each string, and reports ok or malformed at the end.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   req_     | in        | req_valid / req_ready  | req_data (rx_byte, end)
//   rsp_     | out       | rsp_valid / rsp_ready  | rsp_data (string/payload/
//            |           |                        |   done fields)
//
// One request byte per cycle while the queue has room. A byte that yields a
// result goes through the action queue into the output register once that
// is free; header and trailing bytes that yield nothing just update the parser.
// Synchronous active-high reset returns the parser to the string-count phase
// and empties the queue and output register.
// req_ready drops only when the two-entry queue is full, which happens only
// after the consumer has held rsp_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_request_deframer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lprd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lprd_pkg::rsp_type      rsp_data
);

   logic                       req_accept;
   logic                       op_valid;
   lprd_pkg::op_type           front_op;
   lprd_pkg::op_type           head_op;
   lprd_pkg::queue_status_type q_status;
   logic                       op_take;

   // Accept whenever the queue has room.
   assign req_ready  = !q_status.full;
   assign req_accept = req_valid && req_ready;

   // Parse the byte and classify it into an action record.
   lprd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req      (req_data),
      .op_valid (op_valid),
      .op       (front_op)
   );

   // Buffer actions so the parser keeps going while the consumer stalls.
   lprd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (op_valid),
      .push_op (front_op),
      .pop     (op_take),
      .head_op (head_op),
      .status  (q_status)
   );

   // Expand actions into result transactions and hold them for the consumer.
   lprd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_avail  (!q_status.empty),
      .op        (head_op),
      .op_take   (op_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A result never both starts a string and carries a payload byte.
   a_start_xor_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.string_start && rsp_data.payload_valid))
      else $error("string start and payload in one result");

   // Malformed status only accompanies the end of a request.
   a_status_with_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.request_status) |-> rsp_data.request_done)
      else $error("status without request_done");

   // A string's final byte is always a payload byte.
   a_final_is_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.payload_final) |-> rsp_data.payload_valid)
      else $error("payload_final without payload_valid");

   // The queue never takes an action while full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      op_valid |-> !q_status.full)
      else $error("action pushed into a full queue");

endmodule

`default_nettype wire

### rtl/lprd_front.sv
// ----------------------------------------------------------------------------
// lprd_front
// Parser: tracks phase, header assembly and counters, one byte per cycle
// while accept is high, and emits one action record for each byte that
// produces a result.
`default_nettype none

module lprd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire lprd_pkg::req_type req,
   output logic                   op_valid,
   output lprd_pkg::op_type       op
);

   lprd_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          pos_ff, pos_in;
   logic [31:0]         acc_ff, acc_in;
   logic [31:0]         strings_left_ff, strings_left_in;
   logic [31:0]         payload_left_ff, payload_left_in;
   logic [31:0]         current_ff, current_in;
   logic                malformed_ff, malformed_in;

   logic [31:0]         acc_merged;
   logic [31:0]         strings_dec;
   logic [31:0]         payload_dec;

   assign acc_merged  = acc_ff | ({24'd0, req.rx_byte} << {pos_ff, 3'b000});
   assign strings_dec = strings_left_ff - 32'd1;
   assign payload_dec = payload_left_ff - 32'd1;

   always_comb begin
      phase_in        = phase_ff;
      pos_in          = pos_ff;
      acc_in          = acc_ff;
      strings_left_in = strings_left_ff;
      payload_left_in = payload_left_ff;
      current_in      = current_ff;
      malformed_in    = malformed_ff;
      op              = '0;

      case (phase_ff)
         lprd_pkg::PH_COUNT, lprd_pkg::PH_LENGTH: begin
            if (pos_ff == 2'(lprd_pkg::HeaderBytes - 1)) begin
               pos_in = '0;
               acc_in = '0;
               if (phase_ff == lprd_pkg::PH_COUNT) begin
                  strings_left_in = acc_merged;
                  phase_in = (acc_merged == 32'd0) ? lprd_pkg::PH_DONE
                                                   : lprd_pkg::PH_LENGTH;
               end else begin
                  op.start        = 1'b1;
                  op.value        = acc_merged;
                  op.number       = current_ff;
                  payload_left_in = acc_merged;
                  if (acc_merged == 32'd0) begin
                     current_in      = current_ff + 32'd1;
                     strings_left_in = strings_dec;
                     phase_in = (strings_dec == 32'd0) ? lprd_pkg::PH_DONE
                                                       : lprd_pkg::PH_LENGTH;
                  end else begin
                     phase_in = lprd_pkg::PH_PAYLOAD;
                  end
               end
            end else begin
               pos_in = pos_ff + 2'd1;
               acc_in = acc_merged;
            end
         end
         lprd_pkg::PH_PAYLOAD: begin
            op.payload      = 1'b1;
            op.value        = {24'd0, req.rx_byte};
            op.number       = current_ff;
            payload_left_in = payload_dec;
            if (payload_dec == 32'd0) begin
               op.final_byte   = 1'b1;
               current_in      = current_ff + 32'd1;
               strings_left_in = strings_dec;
               phase_in = (strings_dec == 32'd0) ? lprd_pkg::PH_DONE
                                                 : lprd_pkg::PH_LENGTH;
            end
         end
         lprd_pkg::PH_DONE: begin
            malformed_in = 1'b1;
         end
         default: begin
            phase_in = lprd_pkg::PH_COUNT;
         end
      endcase

      if (req.buffer_end) begin
         op.done   = 1'b1;
         op.status = (phase_in != lprd_pkg::PH_DONE) || malformed_in;
         phase_in        = lprd_pkg::PH_COUNT;
         pos_in          = '0;
         acc_in          = '0;
         strings_left_in = '0;
         payload_left_in = '0;
         current_in      = '0;
         malformed_in    = 1'b0;
      end
   end

   assign op_valid = accept && (op.start || op.payload || op.done);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= lprd_pkg::PH_COUNT;
         pos_ff          <= '0;
         acc_ff          <= '0;
         strings_left_ff <= '0;
         payload_left_ff <= '0;
         current_ff      <= '0;
         malformed_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         pos_ff          <= pos_in;
         acc_ff          <= acc_in;
         strings_left_ff <= strings_left_in;
         payload_left_ff <= payload_left_in;
         current_ff      <= current_in;
         malformed_ff    <= malformed_in;
      end
   end

endmodule

`default_nettype wire

### rtl/lprd_queue.sv
// ----------------------------------------------------------------------------
// lprd_queue
// Two-entry action queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lprd_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire lprd_pkg::op_type           push_op,
   input  wire logic                       pop,
   output lprd_pkg::op_type                head_op,
   output lprd_pkg::queue_status_type      status
);

   localparam int unsigned PtrWidth = $clog2(lprd_pkg::QueueDepth);

   lprd_pkg::op_type      mem [lprd_pkg::QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]     count_ff, count_in;

   assign status.full  = (count_ff == (PtrWidth+1)'(lprd_pkg::QueueDepth));
   assign status.empty = (count_ff == '0);
   assign head_op      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrWidth+1)'(push) - (PtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/lprd_back.sv
// ----------------------------------------------------------------------------
// lprd_back
// Output stage: expands action records into result transactions and holds
// each one in a register until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lprd_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             op_avail,
   input  wire lprd_pkg::op_type op,
   output logic                  op_take,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lprd_pkg::rsp_type     rsp_data
);

   logic              valid_ff, valid_in;
   lprd_pkg::rsp_type data_ff, data_in;

   assign op_take = op_avail && (!valid_ff || rsp_ready);

   always_comb begin
      data_in.string_start   = op.start;
      data_in.string_length  = op.start ? op.value : 32'd0;
      data_in.string_number  = (op.start || op.payload) ? op.number : 32'd0;
      data_in.payload_valid  = op.payload;
      data_in.payload_byte   = op.payload ? op.value[7:0] : 8'd0;
      data_in.payload_final  = op.final_byte;
      data_in.request_done   = op.done;
      data_in.request_status = op.status;
      valid_in = op_take || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_take) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the length-prefixed request deframer: a directed
// table of requests followed by random framed, truncated, padded and noise
// requests, results checked against typed rows or a cycle-free predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int ItemTarget = 450;
   localparam int CycleLimit = 400000;

   // One row of the directed table; typed rows carry a hand-written result
   typedef struct {
      lprd_pkg::req_type req;
      bit                typed;
      lprd_pkg::rsp_type rsp;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   lprd_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   lprd_pkg::rsp_type rsp_data;

   // Deframer state as seen by the predictor
   lprd_pkg::phase_type parse_phase;
   logic [1:0]          hdr_pos;
   logic [31:0]         hdr_acc;
   logic [31:0]         strings_left;
   logic [31:0]         payload_left;
   logic [31:0]         string_idx;
   logic                trailing_seen;

   lprd_pkg::rsp_type pending_results[$];
   stim_row_type      directed_rows[$];
   lprd_pkg::req_type frame[$];

   int items_sent  = 0;
   int fail_count  = 0;
   int cycle_count = 0;
   int idle_pct    = 30;

   length_prefixed_request_deframer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   function automatic void restart_parse();
      parse_phase   = lprd_pkg::PH_COUNT;
      hdr_pos       = 2'd0;
      hdr_acc       = 32'd0;
      strings_left  = 32'd0;
      payload_left  = 32'd0;
      string_idx    = 32'd0;
      trailing_seen = 1'b0;
   endfunction

   // Close the current string; advance to the next length header or to the end
   function automatic void close_string();
      string_idx   = string_idx + 32'd1;
      strings_left = strings_left - 32'd1;
      parse_phase  = (strings_left == 32'd0) ? lprd_pkg::PH_DONE : lprd_pkg::PH_LENGTH;
   endfunction

   // Consume one request byte; return 1 when the byte yields a result
   function automatic bit deframe_byte(input lprd_pkg::req_type r,
                                       output lprd_pkg::rsp_type o);
      logic [31:0] hv;
      o = '0;
      case (parse_phase)
         lprd_pkg::PH_COUNT, lprd_pkg::PH_LENGTH: begin
            hdr_acc = hdr_acc | ({24'd0, r.rx_byte} << (8 * hdr_pos));
            if (hdr_pos == 2'd3) begin
               hv      = hdr_acc;
               hdr_pos = 2'd0;
               hdr_acc = 32'd0;
               if (parse_phase == lprd_pkg::PH_COUNT) begin
                  strings_left = hv;
                  parse_phase  = (hv == 32'd0) ? lprd_pkg::PH_DONE
                                               : lprd_pkg::PH_LENGTH;
               end else begin
                  o.string_start  = 1'b1;
                  o.string_length = hv;
                  o.string_number = string_idx;
                  payload_left    = hv;
                  if (hv == 32'd0) begin
                     close_string();
                  end else begin
                     parse_phase = lprd_pkg::PH_PAYLOAD;
                  end
               end
            end else begin
               hdr_pos = hdr_pos + 2'd1;
            end
         end
         lprd_pkg::PH_PAYLOAD: begin
            o.payload_valid = 1'b1;
            o.payload_byte  = r.rx_byte;
            o.string_number = string_idx;
            payload_left    = payload_left - 32'd1;
            if (payload_left == 32'd0) begin
               o.payload_final = 1'b1;
               close_string();
            end
         end
         default: begin
            // anything past the last string poisons the request
            trailing_seen = 1'b1;
         end
      endcase
      if (r.buffer_end) begin
         o.request_done   = 1'b1;
         o.request_status = (parse_phase != lprd_pkg::PH_DONE) || trailing_seen;
         restart_parse();
      end
      return o.string_start | o.payload_valid | o.request_done;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic void add_row(input logic [7:0] b, input logic e);
      stim_row_type row;
      row.req   = lprd_pkg::req_type'{b, e};
      row.typed = 1'b0;
      row.rsp   = '0;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic void add_row_rsp(input logic [7:0] b, input logic e,
                                       input lprd_pkg::rsp_type want);
      stim_row_type row;
      row.req   = lprd_pkg::req_type'{b, e};
      row.typed = 1'b1;
      row.rsp   = want;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) return $urandom_range(1, 2);
      if (pick < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 50);
   endfunction

   function automatic void push_word(input logic [31:0] w);
      for (int k = 0; k < 4; k++) begin
         frame.insert(frame.size(), lprd_pkg::req_type'{w[8*k +: 8], 1'b0});
      end
   endfunction

   function automatic void push_random_byte();
      frame.insert(frame.size(),
                   lprd_pkg::req_type'{8'($urandom_range(0, 255)), 1'b0});
   endfunction

   // Build one request into frame: mostly well formed, the rest padded,
   // cut short, given an oversized header, or plain noise
   function automatic void build_request();
      int                kind;
      int                n;
      int                len;
      int                cut;
      int                idx;
      lprd_pkg::req_type t;
      frame.delete();
      kind = $urandom_range(0, 99);
      if (kind >= 90) begin
         repeat ($urandom_range(1, 12)) push_random_byte();
      end else begin
         n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
         push_word(n);
         repeat (n) begin
            if ($urandom_range(0, 9) == 0) begin
               len = 0;
            end else if ($urandom_range(0, 9) == 0) begin
               len = $urandom_range(9, 40);
            end else begin
               len = $urandom_range(1, 8);
            end
            push_word(len);
            repeat (len) push_random_byte();
         end
         if (kind >= 80) begin
            if ($urandom_range(0, 1) == 1) begin
               // blow up the top byte of the count or of the first length
               idx = (n > 0 && $urandom_range(0, 1) == 1) ? 7 : 3;
               t = frame[idx];
               t.rx_byte = 8'($urandom_range(1, 255));
               frame[idx] = t;
            end else begin
               cut = $urandom_range(1, frame.size() - 1);
               while (frame.size() > cut) void'(frame.pop_back());
            end
         end else if (kind >= 70) begin
            repeat ($urandom_range(1, 3)) push_random_byte();
         end
      end
      t = frame.pop_back();
      t.buffer_end = 1'b1;
      frame.insert(frame.size(), t);
   endfunction

   // Present one byte, hold it until the transaction, then log its result.
   // Called and returns at a falling edge.
   task automatic send_byte(input lprd_pkg::req_type r, input bit typed,
                            input lprd_pkg::rsp_type want);
      lprd_pkg::rsp_type p;
      bit                has;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         repeat (gap_len()) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do begin
         @(posedge clock);
      end while (!req_ready);
      has = deframe_byte(r, p);
      if (typed) begin
         pending_results.insert(pending_results.size(), want);
      end else if (has) begin
         pending_results.insert(pending_results.size(), p);
      end
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every outstanding result has come back
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   function automatic bit field_ok(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : check_results
      lprd_pkg::rsp_type want;
      bit                ok;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result expected none actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            ok = 1'b1;
            ok &= field_ok("string_start", 32'(want.string_start),
                           32'(rsp_data.string_start));
            ok &= field_ok("string_length", want.string_length, rsp_data.string_length);
            ok &= field_ok("string_number", want.string_number, rsp_data.string_number);
            ok &= field_ok("payload_valid", 32'(want.payload_valid),
                           32'(rsp_data.payload_valid));
            ok &= field_ok("payload_byte", 32'(want.payload_byte),
                           32'(rsp_data.payload_byte));
            ok &= field_ok("payload_final", 32'(want.payload_final),
                           32'(rsp_data.payload_final));
            ok &= field_ok("request_done", 32'(want.request_done),
                           32'(rsp_data.request_done));
            ok &= field_ok("request_status", 32'(want.request_status),
                           32'(rsp_data.request_status));
            if (!ok) fail_count++;
         end
      end
   end

   // Give up on a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Consumer: alternate ready bursts, short and long, with stalls
   initial begin
      rsp_ready = 1'b1;
      forever begin
         repeat (($urandom_range(0, 1) == 0) ? $urandom_range(1, 6)
                                             : $urandom_range(20, 150))
            @(negedge clock);
         rsp_ready = 1'b0;
         repeat (gap_len()) @(negedge clock);
         rsp_ready = 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------

   initial begin
      int requests;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      restart_parse();

      // Two strings, the second empty; end lands on the empty string's header
      add_row(8'h02, 1'b0); add_row(8'h00, 1'b0);
      add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
      add_row(8'h02, 1'b0); add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
      add_row_rsp(8'h00, 1'b0, lprd_pkg::rsp_type'{1'b1, 32'd2, 32'd0, 1'b0, 8'h00,
                                                   1'b0, 1'b0, 1'b0});
      add_row(8'hff, 1'b0); add_row(8'h00, 1'b0);
      add_row(8'h00, 1'b0); add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
      add_row_rsp(8'h00, 1'b1, lprd_pkg::rsp_type'{1'b1, 32'd0, 32'd1, 1'b0, 8'h00,
                                                   1'b0, 1'b1, 1'b0});
      // Zero string count, then trailing bytes: malformed
      add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
      add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
      add_row(8'haa, 1'b0);
      add_row_rsp(8'h55, 1'b1, lprd_pkg::rsp_type'{1'b0, 32'd0, 32'd0, 1'b0, 8'h00,
                                                   1'b0, 1'b1, 1'b1});
      // Maximum string count, stream ends right after it: short
      add_row(8'hff, 1'b0); add_row(8'hff, 1'b0); add_row(8'hff, 1'b0);
      add_row_rsp(8'hff, 1'b1, lprd_pkg::rsp_type'{1'b0, 32'd0, 32'd0, 1'b0, 8'h00,
                                                   1'b0, 1'b1, 1'b1});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      end
      wait_drained();

      // Random requests; every tenth one, hold off until the block drains
      requests = 0;
      while (items_sent < ItemTarget) begin
         build_request();
         idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
         foreach (frame[i]) send_byte(frame[i], 1'b0, '0);
         requests++;
         if (requests % 10 == 0) wait_drained();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
